// ----- design/brf_pkg.sv -----
// ----------------------------------------------------------------------------
// brf_pkg
// Shared command codes and stream widths for the byte ring queue with search.
// ----------------------------------------------------------------------------
`default_nettype none

package brf_pkg;

    localparam int CMD_W       = 3;
    localparam int BYTE_W      = 8;
    localparam int FIELD_W     = 6;
    localparam int IN_TDATA_W  = 24;
    localparam int OUT_TDATA_W = 24;

    localparam logic [CMD_W-1:0] CMD_PUSH   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_POP    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_PEEK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_PEEKAT = 3'd3;
    localparam logic [CMD_W-1:0] CMD_FIND   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_FLUSH  = 3'd5;
    localparam logic [CMD_W-1:0] CMD_SETRD  = 3'd6;

endpackage

`default_nettype wire

// ----- design/brf_ram.sv -----
// ----------------------------------------------------------------------------
// brf_ram
// Byte slot store: one write port and one read port with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_ram #(
    parameter int DEPTH = 64,
    parameter int AW    = 6
) (
    input  wire logic                       clk,
    input  wire logic                       we,
    input  wire logic [AW-1:0]              waddr,
    input  wire logic [brf_pkg::BYTE_W-1:0] wdata,
    input  wire logic [AW-1:0]              raddr,
    output logic      [brf_pkg::BYTE_W-1:0] rdata
);

    logic [brf_pkg::BYTE_W-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    always_ff @(posedge clk)
    begin
        rdata <= mem[raddr];
    end

endmodule

`default_nettype wire

// ----- design/brf_wrap_unit.sv -----
// ----------------------------------------------------------------------------
// brf_wrap_unit
// Shared compare-subtract step: reduces a value by the ring size once.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_wrap_unit #(
    parameter int SLOTS = 64,
    parameter int XW    = 8
) (
    input  wire logic [XW-1:0] x,
    output logic      [XW-1:0] y,
    output logic               ge
);

    localparam logic [XW-1:0] SLOTS_X = XW'(SLOTS);

    always_comb
    begin
        ge = (x >= SLOTS_X);
        y  = ge ? (x - SLOTS_X) : x;
    end

endmodule

`default_nettype wire

// ----- design/byte_ring_fifo_with_search.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search
// Circular byte queue with push, pop, peek, peek at offset, find, flush and
// set read pointer commands; one result per command.
// ----------------------------------------------------------------------------
// One command is taken at a time; s_axis_tready is low while a command is
// being worked on. Every command passes through a single compare-subtract
// unit and a byte store with one registered read port. Set read pointer and
// peek at offset subtract QUEUE_SLOTS from the position, or from read
// pointer plus offset, until it is in range; find reads and compares one
// slot at a time until a match or the write pointer; flush runs a clearing
// sweep over the store. After reset the store is cleared before the first
// command is taken. A finished result waits in an output register, and the
// next command may be accepted while it waits; that command then holds in
// its final state until the output register is free.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_with_search #(
    parameter int QUEUE_SLOTS = 64
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_axis_tvalid,
    output logic                                 s_axis_tready,
    // data_byte[7:0], offset[13:8], position[19:14]
    input  wire logic [brf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // command[2:0]
    input  wire logic [brf_pkg::CMD_W-1:0]       s_axis_tuser,
    output logic                                 m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    // data_out[7:0], empty_res[8], dropped[9], found[10], found_slot[16:11],
    // fill_count[22:17]
    output logic      [brf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    localparam int PW = $clog2(QUEUE_SLOTS);
    localparam int XW = $clog2(2 * QUEUE_SLOTS + 64);
    localparam logic [PW-1:0] LAST_SLOT = PW'(QUEUE_SLOTS - 1);

    localparam logic [2:0] S_CLEAR    = 3'd0;
    localparam logic [2:0] S_IDLE     = 3'd1;
    localparam logic [2:0] S_PUSH     = 3'd2;
    localparam logic [2:0] S_RDWAIT   = 3'd3;
    localparam logic [2:0] S_MOD      = 3'd4;
    localparam logic [2:0] S_SCAN_RD  = 3'd5;
    localparam logic [2:0] S_SCAN_CMP = 3'd6;
    localparam logic [2:0] S_FILL     = 3'd7;

    logic [2:0]                       state_reg, state_next;
    logic [PW-1:0]                    wr_reg, wr_next;
    logic [PW-1:0]                    rd_reg, rd_next;
    logic [PW-1:0]                    clr_reg, clr_next;
    logic                             flush_reg, flush_next;
    logic [XW-1:0]                    x_reg, x_next;
    logic [PW-1:0]                    scan_reg, scan_next;
    logic [brf_pkg::CMD_W-1:0]        cmd_reg, cmd_next;
    logic [brf_pkg::BYTE_W-1:0]       byte_reg, byte_next;
    logic [brf_pkg::BYTE_W-1:0]       data_reg, data_next;
    logic                             empty_reg, empty_next;
    logic                             drop_reg, drop_next;
    logic                             hit_reg, hit_next;
    logic [PW-1:0]                    slot_reg, slot_next;
    logic                             m_valid_reg, m_valid_next;
    logic [brf_pkg::OUT_TDATA_W-1:0]  m_data_reg, m_data_next;

    logic                             accept;
    logic                             ram_we;
    logic [PW-1:0]                    ram_waddr;
    logic [brf_pkg::BYTE_W-1:0]       ram_wdata;
    logic [PW-1:0]                    ram_raddr;
    logic [brf_pkg::BYTE_W-1:0]       ram_rdata;
    logic [XW-1:0]                    unit_x;
    logic [XW-1:0]                    unit_y;
    logic                             unit_ge;

    logic [brf_pkg::BYTE_W-1:0]       in_byte;
    logic [brf_pkg::FIELD_W-1:0]      in_offset;
    logic [brf_pkg::FIELD_W-1:0]      in_position;

    assign in_byte     = s_axis_tdata[7:0];
    assign in_offset   = s_axis_tdata[13:8];
    assign in_position = s_axis_tdata[19:14];

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;

    brf_ram #(
        .DEPTH (QUEUE_SLOTS),
        .AW    (PW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // fill count operand goes through the same unit
    assign unit_x = (state_reg == S_FILL)
                  ? (XW'(wr_reg) + XW'(QUEUE_SLOTS) - XW'(rd_reg))
                  : x_reg;

    brf_wrap_unit #(
        .SLOTS (QUEUE_SLOTS),
        .XW    (XW)
    ) u_unit (
        .x  (unit_x),
        .y  (unit_y),
        .ge (unit_ge)
    );

    always_comb
    begin
        state_next   = state_reg;
        wr_next      = wr_reg;
        rd_next      = rd_reg;
        clr_next     = clr_reg;
        flush_next   = flush_reg;
        x_next       = x_reg;
        scan_next    = scan_reg;
        cmd_next     = cmd_reg;
        byte_next    = byte_reg;
        data_next    = data_reg;
        empty_next   = empty_reg;
        drop_next    = drop_reg;
        hit_next     = hit_reg;
        slot_next    = slot_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        ram_we       = 1'b0;
        ram_waddr    = wr_reg;
        ram_wdata    = byte_reg;
        ram_raddr    = rd_reg;

        case (state_reg)
            S_CLEAR:
            begin
                ram_we    = 1'b1;
                ram_waddr = clr_reg;
                ram_wdata = '0;
                if (clr_reg == LAST_SLOT)
                begin
                    clr_next   = '0;
                    flush_next = 1'b0;
                    state_next = flush_reg ? S_FILL : S_IDLE;
                end
                else
                begin
                    clr_next = clr_reg + PW'(1);
                end
            end

            S_IDLE:
            begin
                ram_raddr = rd_reg;
                if (accept)
                begin
                    cmd_next   = s_axis_tuser;
                    byte_next  = in_byte;
                    data_next  = '0;
                    empty_next = 1'b0;
                    drop_next  = 1'b0;
                    hit_next   = 1'b0;
                    slot_next  = '0;
                    case (s_axis_tuser)
                        brf_pkg::CMD_PUSH:
                        begin
                            x_next     = XW'(wr_reg) + XW'(1);
                            state_next = S_PUSH;
                        end
                        brf_pkg::CMD_POP, brf_pkg::CMD_PEEK:
                        begin
                            if (wr_reg == rd_reg)
                            begin
                                empty_next = 1'b1;
                                state_next = S_FILL;
                            end
                            else
                            begin
                                x_next     = XW'(rd_reg) + XW'(1);
                                state_next = S_RDWAIT;
                            end
                        end
                        brf_pkg::CMD_PEEKAT:
                        begin
                            x_next     = XW'(rd_reg) + XW'(in_offset);
                            state_next = S_MOD;
                        end
                        brf_pkg::CMD_FIND:
                        begin
                            scan_next  = rd_reg;
                            state_next = S_SCAN_RD;
                        end
                        brf_pkg::CMD_FLUSH:
                        begin
                            wr_next    = '0;
                            rd_next    = '0;
                            clr_next   = '0;
                            flush_next = 1'b1;
                            state_next = S_CLEAR;
                        end
                        brf_pkg::CMD_SETRD:
                        begin
                            x_next     = XW'(in_position);
                            state_next = S_MOD;
                        end
                        default:
                        begin
                            state_next = S_FILL;
                        end
                    endcase
                end
            end

            S_PUSH:
            begin
                if (unit_y[PW-1:0] != rd_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = wr_reg;
                    ram_wdata = byte_reg;
                    wr_next   = unit_y[PW-1:0];
                end
                else
                begin
                    drop_next = 1'b1;
                end
                state_next = S_FILL;
            end

            S_RDWAIT:
            begin
                data_next = ram_rdata;
                if (cmd_reg == brf_pkg::CMD_POP)
                begin
                    rd_next = unit_y[PW-1:0];
                end
                state_next = S_FILL;
            end

            S_MOD:
            begin
                ram_raddr = x_reg[PW-1:0];
                if (unit_ge)
                begin
                    x_next = unit_y;
                end
                else if (cmd_reg == brf_pkg::CMD_SETRD)
                begin
                    rd_next    = x_reg[PW-1:0];
                    state_next = S_FILL;
                end
                else
                begin
                    state_next = S_RDWAIT;
                end
            end

            S_SCAN_RD:
            begin
                ram_raddr = scan_reg;
                if (scan_reg == wr_reg)
                begin
                    state_next = S_FILL;
                end
                else
                begin
                    x_next     = XW'(scan_reg) + XW'(1);
                    state_next = S_SCAN_CMP;
                end
            end

            S_SCAN_CMP:
            begin
                if (ram_rdata == byte_reg)
                begin
                    hit_next   = 1'b1;
                    slot_next  = scan_reg;
                    state_next = S_FILL;
                end
                else
                begin
                    scan_next  = unit_y[PW-1:0];
                    state_next = S_SCAN_RD;
                end
            end

            S_FILL:
            begin
                if (!m_valid_reg || m_axis_tready)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = {1'b0, 6'(unit_y), 6'(slot_reg), hit_reg, drop_reg,
                                    empty_reg, data_reg};
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_CLEAR;
            wr_reg      <= '0;
            rd_reg      <= '0;
            clr_reg     <= '0;
            flush_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            wr_reg      <= wr_next;
            rd_reg      <= rd_next;
            clr_reg     <= clr_next;
            flush_reg   <= flush_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg      <= x_next;
        scan_reg   <= scan_next;
        cmd_reg    <= cmd_next;
        byte_reg   <= byte_next;
        data_reg   <= data_next;
        empty_reg  <= empty_next;
        drop_reg   <= drop_next;
        hit_reg    <= hit_next;
        slot_reg   <= slot_next;
        m_data_reg <= m_data_next;
    end

endmodule

`default_nettype wire

// ----- design/brf_checker.sv -----
// ----------------------------------------------------------------------------
// brf_checker
// Port-level checks for the byte ring queue, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module brf_checker (
    input wire logic                            clk,
    input wire logic                            rst_n,
    input wire logic                            s_axis_tvalid,
    input wire logic                            s_axis_tready,
    input wire logic [brf_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    input wire logic [brf_pkg::CMD_W-1:0]       s_axis_tuser,
    input wire logic                            m_axis_tvalid,
    input wire logic                            m_axis_tready,
    input wire logic [brf_pkg::OUT_TDATA_W-1:0] m_axis_tdata
);

    // ready is low in the cycle after a request is accepted
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("ready did not drop after a request");

    // a new result appears exactly as the block returns to idle
    a_result_on_return: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> s_axis_tready && $past(!s_axis_tready))
        else $error("result appeared without finishing a request");

    // empty, dropped and found are mutually exclusive
    a_flags_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $countones(m_axis_tdata[10:8]) <= 1)
        else $error("more than one status flag set in a result");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

endmodule

bind byte_ring_fifo_with_search brf_checker u_brf_checker (.*);

`default_nettype wire

// ----- sim/byte_ring_fifo_with_search_test.sv -----
// ----------------------------------------------------------------------------
// byte_ring_fifo_with_search_test
// Drives push, pop, peek, peek at offset, find, flush and set read pointer
// commands into the byte ring queue over the request stream, keeps a model of
// the ring and both pointers, and checks every returned reply field by field.
// A short directed part covers the empty, full and wrap corners; random
// phases then bias toward filling, draining, mixed use and searching, with
// bursty requests and a stalling reply side.
// ----------------------------------------------------------------------------
`default_nettype none

module byte_ring_fifo_with_search_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int SLOTS        = 64;
    localparam int RANDOM_ITEMS = 2000;
    localparam int HOLD_CYCLES  = 400;
    localparam int TAIL_CYCLES  = 200;
    localparam int LIMIT        = 2000000;
    localparam int PRINT_CAP    = 50;

    localparam logic [brf_pkg::CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef enum int {PH_FILL, PH_DRAIN, PH_MIXED, PH_SEARCH} phase_t;

    typedef struct packed {
        logic [brf_pkg::FIELD_W-1:0] fill_count;
        logic [brf_pkg::FIELD_W-1:0] found_slot;
        logic                        found;
        logic                        dropped;
        logic                        empty_res;
        logic [brf_pkg::BYTE_W-1:0]  data_out;
    } reply_t;

    class ring_scoreboard;
        logic [brf_pkg::BYTE_W-1:0]  ring [SLOTS];
        logic [brf_pkg::FIELD_W-1:0] wr_ptr;
        logic [brf_pkg::FIELD_W-1:0] rd_ptr;
        reply_t                      expected_replies [$];
        int                          errors;
        int                          replies_seen;

        function new();
            foreach (ring[i]) ring[i] = '0;
            wr_ptr = '0;
            rd_ptr = '0;
            errors = 0;
            replies_seen = 0;
        endfunction

        function int pending();
            return expected_replies.size();
        endfunction

        task report(string msg);
            errors++;
            if (errors <= PRINT_CAP)
                $display("[%0t] mismatch: %s", $realtime, msg);
        endtask

        function void note_command(logic [brf_pkg::CMD_W-1:0] cmd,
                                   logic [brf_pkg::BYTE_W-1:0] value,
                                   logic [brf_pkg::FIELD_W-1:0] offset,
                                   logic [brf_pkg::FIELD_W-1:0] position);
            reply_t                      r;
            logic [brf_pkg::FIELD_W-1:0] p;
            int                          n;
            bit                          done;
            r = '0;
            case (cmd)
                brf_pkg::CMD_PUSH:
                begin
                    p = wr_ptr + 6'd1;
                    if (p != rd_ptr)
                    begin
                        ring[wr_ptr] = value;
                        wr_ptr = p;
                    end
                    else
                        r.dropped = 1'b1;
                end
                brf_pkg::CMD_POP:
                begin
                    if (wr_ptr == rd_ptr)
                        r.empty_res = 1'b1;
                    else
                    begin
                        r.data_out = ring[rd_ptr];
                        rd_ptr = rd_ptr + 6'd1;
                    end
                end
                brf_pkg::CMD_PEEK:
                begin
                    if (wr_ptr == rd_ptr)
                        r.empty_res = 1'b1;
                    else
                        r.data_out = ring[rd_ptr];
                end
                brf_pkg::CMD_PEEKAT:
                begin
                    p = rd_ptr + offset;
                    r.data_out = ring[p];
                end
                brf_pkg::CMD_FIND:
                begin
                    p = rd_ptr;
                    done = 0;
                    for (n = 0; n < SLOTS && !done && p != wr_ptr; n++)
                    begin
                        if (ring[p] == value)
                        begin
                            r.found = 1'b1;
                            r.found_slot = p;
                            done = 1;
                        end
                        else
                            p = p + 6'd1;
                    end
                end
                brf_pkg::CMD_FLUSH:
                begin
                    foreach (ring[i]) ring[i] = '0;
                    wr_ptr = '0;
                    rd_ptr = '0;
                end
                brf_pkg::CMD_SETRD:
                    rd_ptr = position;
                default:
                    ;
            endcase
            r.fill_count = wr_ptr - rd_ptr;
            expected_replies.push_back(r);
        endfunction

        task check_result(logic [brf_pkg::OUT_TDATA_W-1:0] t);
            reply_t e;
            replies_seen++;
            if (expected_replies.size() == 0)
            begin
                report($sformatf("reply %0d arrived with nothing pending", replies_seen));
                return;
            end
            e = expected_replies.pop_front();
            if (t[7:0] !== e.data_out)
                report($sformatf("reply %0d data_out %h, expected %h",
                                 replies_seen, t[7:0], e.data_out));
            if (t[8] !== e.empty_res)
                report($sformatf("reply %0d empty_res %b, expected %b",
                                 replies_seen, t[8], e.empty_res));
            if (t[9] !== e.dropped)
                report($sformatf("reply %0d dropped %b, expected %b",
                                 replies_seen, t[9], e.dropped));
            if (t[10] !== e.found)
                report($sformatf("reply %0d found %b, expected %b",
                                 replies_seen, t[10], e.found));
            if (t[16:11] !== e.found_slot)
                report($sformatf("reply %0d found_slot %0d, expected %0d",
                                 replies_seen, t[16:11], e.found_slot));
            if (t[22:17] !== e.fill_count)
                report($sformatf("reply %0d fill_count %0d, expected %0d",
                                 replies_seen, t[22:17], e.fill_count));
        endtask
    endclass

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [brf_pkg::IN_TDATA_W-1:0]  s_axis_tdata = '0;
    logic [brf_pkg::CMD_W-1:0]       s_axis_tuser = '0;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [brf_pkg::OUT_TDATA_W-1:0] m_axis_tdata;

    ring_scoreboard sb = new();

    int          cycle_count = 0;
    int          hold_requests = 0;
    int          hold_served = 0;
    int          hold_left = 0;
    logic [31:0] rx_cycle = '0;

    byte_ring_fifo_with_search #(
        .QUEUE_SLOTS (SLOTS)
    ) DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    always #2 clk = ~clk;

    always @(posedge clk)
        cycle_count <= cycle_count + 1;

    initial
    begin
        wait (cycle_count >= LIMIT);
        $display("byte_ring_fifo_with_search verification failed");
        $finish;
    end

    // reply side: long hold-off on request, else a rotating stall pattern
    always @(negedge clk)
    begin
        rx_cycle <= rx_cycle + 1;
        if (hold_requests != hold_served)
        begin
            hold_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left = hold_left - 1;
            m_axis_tready <= 1'b0;
        end
        else
        begin
            case (rx_cycle[7:6])
                2'd0: m_axis_tready <= 1'b1;
                2'd1: m_axis_tready <= 1'($urandom_range(0, 1));
                2'd2: m_axis_tready <= ($urandom_range(0, 3) == 0);
                default: m_axis_tready <= (rx_cycle[2:0] != 3'd0);
            endcase
        end
    end

    always @(posedge clk)
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tdata);

    task send_command(logic [brf_pkg::CMD_W-1:0] cmd, logic [brf_pkg::BYTE_W-1:0] value,
                      logic [brf_pkg::FIELD_W-1:0] offset,
                      logic [brf_pkg::FIELD_W-1:0] position);
        @(negedge clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= cmd;
        s_axis_tdata  <= brf_pkg::IN_TDATA_W'({position, offset, value});
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
        sb.note_command(cmd, value, offset, position);
    endtask

    task idle_sender(int cycles);
        if (cycles > 0)
        begin
            @(negedge clk);
            s_axis_tvalid <= 1'b0;
            repeat (cycles - 1) @(negedge clk);
        end
    endtask

    task drain_results();
        @(negedge clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge clk);
    endtask

    function automatic logic [brf_pkg::CMD_W-1:0] pick_command(phase_t ph);
        int cut [7];
        int r;
        case (ph)
            PH_FILL:   cut = '{70, 80, 84, 88, 95, 97, 98};
            PH_DRAIN:  cut = '{20, 75, 82, 88, 95, 97, 98};
            PH_MIXED:  cut = '{40, 70, 77, 84, 93, 96, 98};
            default:   cut = '{35, 45, 50, 60, 95, 97, 98};
        endcase
        r = $urandom_range(0, 99);
        if (r < cut[0]) return brf_pkg::CMD_PUSH;
        if (r < cut[1]) return brf_pkg::CMD_POP;
        if (r < cut[2]) return brf_pkg::CMD_PEEK;
        if (r < cut[3]) return brf_pkg::CMD_PEEKAT;
        if (r < cut[4]) return brf_pkg::CMD_FIND;
        if (r < cut[5]) return brf_pkg::CMD_SETRD;
        if (r < cut[6]) return brf_pkg::CMD_FLUSH;
        return CMD_UNUSED;
    endfunction

    initial
    begin
        int                        i;
        int                        burst_left;
        phase_t                    ph;
        logic [brf_pkg::CMD_W-1:0] cmd;
        logic [7:0]                value;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // empty queue corners
        send_command(brf_pkg::CMD_POP,    8'h00, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_PEEK,   8'h00, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_FIND,   8'h00, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_PEEKAT, 8'h00, 6'd63, 6'd0);
        send_command(brf_pkg::CMD_PUSH,   8'h00, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_PUSH,   8'hff, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_PUSH,   8'ha5, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_PEEK,   8'h00, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_PEEKAT, 8'h00, 6'd1,  6'd0);
        send_command(brf_pkg::CMD_PEEKAT, 8'h00, 6'd63, 6'd0);
        send_command(brf_pkg::CMD_FIND,   8'hff, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_FIND,   8'h5a, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_POP,    8'h00, 6'd0,  6'd0);
        send_command(CMD_UNUSED,          8'hff, 6'd63, 6'd63);
        // read pointer moved behind write pointer, stale slot popped
        send_command(brf_pkg::CMD_SETRD,  8'h00, 6'd0,  6'd63);
        send_command(brf_pkg::CMD_POP,    8'h00, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_SETRD,  8'h00, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_FLUSH,  8'h00, 6'd0,  6'd0);
        // read pointer one ahead of write pointer: full, push dropped
        send_command(brf_pkg::CMD_SETRD,  8'h00, 6'd0,  6'd1);
        send_command(brf_pkg::CMD_PUSH,   8'h3c, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_FIND,   8'hff, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_FIND,   8'h00, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_POP,    8'h00, 6'd0,  6'd0);
        send_command(brf_pkg::CMD_FLUSH,  8'h00, 6'd0,  6'd0);
        drain_results();

        hold_requests++;
        burst_left = 0;
        ph = PH_FILL;
        for (i = 0; i < RANDOM_ITEMS; i++)
        begin
            if (i != 0 && i % 250 == 0)
                ph = phase_t'($urandom_range(0, 3));
            if (i == RANDOM_ITEMS / 2)
                drain_results();
            if (burst_left == 0)
            begin
                burst_left = $urandom_range(1, 16);
                if ($urandom_range(0, 3) != 0)
                    idle_sender($urandom_range(1, 8));
            end
            burst_left--;
            cmd = pick_command(ph);
            if ($urandom_range(0, 1))
                value = 8'($urandom_range(0, 255));
            else
                value = 8'($urandom_range(0, 15));
            send_command(cmd, value, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
        end
        drain_results();

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d replies never arrived", sb.pending()));

        if (sb.errors == 0)
            $display("byte_ring_fifo_with_search verification clean");
        else
            $display("byte_ring_fifo_with_search verification failed");
        $finish;
    end

endmodule

`default_nettype wire
